FILE: rtl/core/positional_insert_queue_macros.svh
// Assertion macros for the positional insert queue.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef POSITIONAL_INSERT_QUEUE_MACROS_SVH
`define POSITIONAL_INSERT_QUEUE_MACROS_SVH

// same-cycle implication, checked out of reset
`define PIQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PIQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/piq_pkg.sv
// Shared types and constants of the positional insert queue.
// No dependencies; used by piq_cell and positional_insert_queue.
package piq_pkg;

  localparam int unsigned DepthDefault = 64;
  localparam int unsigned PosW         = 7;
  localparam int unsigned CountW       = 7;
  localparam int unsigned ValW         = 32;

  typedef enum logic [2:0] {
    OpAppend = 3'd0,
    OpHead   = 3'd1,
    OpAt     = 3'd2,
    OpPop    = 3'd3,
    OpClear  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2,
    StRange = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]             op;
    logic signed [ValW-1:0] item_value;
    logic [PosW-1:0]        position;
  } in_t;

  typedef struct packed {
    logic signed [ValW-1:0] popped_value;
    logic [CountW-1:0]      count;
    status_e                status;
  } out_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/positional_insert_queue.sv
// Top level of the positional insert queue: request decode, length register and result beat.
// Depends on piq_pkg, piq_cell and positional_insert_queue_macros.svh.
//
// An ordered store of up to DEPTH signed 32-bit values. One request is taken per clock cycle
// and its result beat is registered for the next cycle; a new request is taken while the result
// register is empty or being drained in the same cycle. Every operation completes as it is
// accepted, because the row of cells shifts all entries at once. Stored values are undefined
// until written; only entries below the length are ever returned, so reset needs no sweep.
`include "positional_insert_queue_macros.svh"

module positional_insert_queue #(
  parameter int unsigned DEPTH = piq_pkg::DepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  piq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output piq_pkg::out_t out_data_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > piq_pkg::PosW) ? CntW : piq_pkg::PosW;
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

  logic [CntW-1:0]     occ_q, occ_d;
  logic                out_valid_q;
  piq_pkg::out_t       out_data_q, res;
  piq_pkg::status_e    status;
  logic                accept;
  logic                ins, pop, clr;
  logic [IdxW-1:0]     at;
  logic                full;
  logic [CmpW-1:0]     pos_ext, occ_ext, occ_next_ext;
  piq_pkg::cell_ctrl_t ctrl;

  logic signed [piq_pkg::ValW-1:0] cell_val [DEPTH];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign full    = (occ_q == DepthC);
  assign pos_ext = CmpW'(in_data_i.position);
  assign occ_ext = CmpW'(occ_q);

  always_comb begin
    ins    = 1'b0;
    pop    = 1'b0;
    clr    = 1'b0;
    at     = '0;
    status = piq_pkg::StOk;
    case (in_data_i.op)
      piq_pkg::OpAppend: begin
        if (full) begin
          status = piq_pkg::StFull;
        end else begin
          ins = 1'b1;
          at  = occ_q[IdxW-1:0];
        end
      end
      piq_pkg::OpHead: begin
        if (full) begin
          status = piq_pkg::StFull;
        end else begin
          ins = 1'b1;
        end
      end
      piq_pkg::OpAt: begin
        if (full) begin
          status = piq_pkg::StFull;
        end else if (pos_ext > occ_ext) begin
          status = piq_pkg::StRange;
        end else begin
          ins = 1'b1;
          at  = pos_ext[IdxW-1:0];
        end
      end
      piq_pkg::OpPop: begin
        if (occ_q == '0) begin
          status = piq_pkg::StEmpty;
        end else begin
          pop = 1'b1;
        end
      end
      piq_pkg::OpClear: begin
        clr = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    occ_d = occ_q;
    if (clr) begin
      occ_d = '0;
    end else if (ins) begin
      occ_d = occ_q + CntW'(1);
    end else if (pop) begin
      occ_d = occ_q - CntW'(1);
    end
  end

  assign occ_next_ext     = CmpW'(occ_d);
  assign res.status       = status;
  assign res.count        = occ_next_ext[piq_pkg::CountW-1:0];
  assign res.popped_value = pop ? cell_val[0] : '0;

  assign ctrl.ins = accept && ins;
  assign ctrl.pop = accept && pop;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [piq_pkg::ValW-1:0] left, right;
    if (k == 0) begin : g_first
      assign left = cell_val[k];
    end else begin : g_mid
      assign left = cell_val[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right = cell_val[k];
    end else begin : g_inner
      assign right = cell_val[k+1];
    end
    piq_cell #(
      .IDX_W (IdxW),
      .INDEX (k)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .at_i    (at),
      .item_i  (in_data_i.item_value),
      .left_i  (left),
      .right_i (right),
      .val_o   (cell_val[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        occ_q <= occ_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `PIQ_ASSERT_NOW(a_occ_bound, 1'b1, occ_q <= DepthC, "length beyond capacity")
  `PIQ_ASSERT_NEXT(a_ins_grow, accept && ins, occ_q == $past(occ_q) + CntW'(1), "len not grown")
  `PIQ_ASSERT_NEXT(a_pop_shrink, accept && pop, occ_q == $past(occ_q) - CntW'(1), "not shrunk")
  `PIQ_ASSERT_NEXT(a_clear, accept && clr, occ_q == '0, "clear left entries")

endmodule

FILE: rtl/core/piq_cell.sv
// One storage cell of the queue chain: holds a value, takes from a neighbour or the new item.
// Depends on piq_pkg.
module piq_cell #(
  parameter int unsigned IDX_W = 6,
  parameter int unsigned INDEX = 0
) (
  input  logic                            clk_i,
  input  piq_pkg::cell_ctrl_t             ctrl_i,
  input  logic [IDX_W-1:0]                at_i,
  input  logic signed [piq_pkg::ValW-1:0] item_i,
  input  logic signed [piq_pkg::ValW-1:0] left_i,
  input  logic signed [piq_pkg::ValW-1:0] right_i,
  output logic signed [piq_pkg::ValW-1:0] val_o
);

  localparam logic [IDX_W-1:0] Idx = INDEX[IDX_W-1:0];

  logic signed [piq_pkg::ValW-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins) begin
      if (Idx == at_i) begin
        val_d = item_i;
      end else if (Idx > at_i) begin
        val_d = left_i;
      end
    end else if (ctrl_i.pop) begin
      val_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

FILE: test/tb_positional_insert_queue.sv
// Testbench for positional_insert_queue: a directed table, then random bursts of requests, every result
// beat checked against the table's expected result or an in-bench shadow of the stored values.
// Depends on piq_pkg and the positional_insert_queue RTL.
module tb_positional_insert_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import piq_pkg::*;

  localparam int unsigned QueueDepth = DepthDefault;
  localparam int unsigned ItemTarget = 1100;
  localparam logic [2:0]  OpSpareLo  = 3'd5;
  localparam logic [2:0]  OpSpareMid = 3'd6;
  localparam logic [2:0]  OpSpareHi  = 3'd7;

  typedef enum int {BurstFill, BurstDrain, BurstBlend, BurstEdge} burst_e;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t want;
  } plan_row_t;

  logic clk_i;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  logic signed [ValW-1:0] shadow_q[$];
  out_t                   result_q[$];
  plan_row_t              plan[$];
  int                     error_count   = 0;
  int                     beats_seen    = 0;
  int                     items_sent    = 0;
  bit                     sender_calm   = 1'b0;
  bit                     receiver_calm = 1'b0;

  positional_insert_queue #(
    .DEPTH(QueueDepth)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #5ms;
    $display("tb_positional_insert_queue: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("beat %0d: %s got %0h, want %0h", beats_seen, field, got, want);
    error_count++;
  endtask

  function automatic out_t shadow_apply(input in_t req);
    out_t res;
    res.popped_value = '0;
    res.status       = StOk;
    case (req.op)
      OpAppend, OpHead, OpAt: begin
        if (shadow_q.size() >= QueueDepth) begin
          res.status = StFull;
        end else if (req.op == OpAt && req.position > shadow_q.size()) begin
          res.status = StRange;
        end else if (req.op == OpAppend) begin
          shadow_q.insert(shadow_q.size(), req.item_value);
        end else if (req.op == OpHead) begin
          shadow_q.insert(0, req.item_value);
        end else begin
          shadow_q.insert(req.position, req.item_value);
        end
      end
      OpPop: begin
        if (shadow_q.size() == 0) begin
          res.status = StEmpty;
        end else begin
          res.popped_value = shadow_q.pop_front();
        end
      end
      OpClear: begin
        shadow_q.delete();
      end
      default: ;
    endcase
    res.count = CountW'(shadow_q.size());
    return res;
  endfunction

  function automatic void plan_row(input logic [2:0] op, input logic [ValW-1:0] value,
                                   input logic [PosW-1:0] pos, input bit typed = 1'b0,
                                   input logic [ValW-1:0] popped = '0,
                                   input logic [CountW-1:0] count = '0,
                                   input status_e status = StOk);
    plan_row_t row;
    row.req.op            = op;
    row.req.item_value    = value;
    row.req.position      = pos;
    row.typed             = typed;
    row.want.popped_value = popped;
    row.want.count        = count;
    row.want.status       = status;
    plan.insert(plan.size(), row);
  endfunction

  function automatic in_t random_request(input burst_e kind);
    in_t         req;
    int unsigned len;
    int unsigned roll;
    len  = shadow_q.size();
    roll = $urandom_range(0, 99);
    case ($urandom_range(0, 15))
      0:       req.item_value = 32'h8000_0000;
      1:       req.item_value = 32'h7fff_ffff;
      2:       req.item_value = 32'hffff_ffff;
      3:       req.item_value = '0;
      default: req.item_value = $urandom;
    endcase
    req.position = PosW'($urandom_range(0, len));
    case (kind)
      BurstFill: begin
        if (roll < 30)      req.op = OpAppend;
        else if (roll < 55) req.op = OpHead;
        else if (roll < 88) req.op = OpAt;
        else if (roll < 98) req.op = OpPop;
        else                req.op = 3'($urandom_range(OpSpareLo, OpSpareHi));
      end
      BurstDrain: begin
        if (roll < 70)      req.op = OpPop;
        else if (roll < 80) req.op = OpAppend;
        else if (roll < 88) req.op = OpHead;
        else if (roll < 96) req.op = OpAt;
        else if (roll < 98) req.op = OpClear;
        else                req.op = OpSpareMid;
      end
      BurstBlend: begin
        if (roll < 20)      req.op = OpAppend;
        else if (roll < 40) req.op = OpHead;
        else if (roll < 65) req.op = OpAt;
        else if (roll < 90) req.op = OpPop;
        else if (roll < 94) req.op = OpClear;
        else                req.op = 3'($urandom_range(OpSpareLo, OpSpareHi));
      end
      default: begin
        if (roll < 75)      req.op = OpAt;
        else if (roll < 85) req.op = OpAppend;
        else if (roll < 95) req.op = OpPop;
        else                req.op = OpClear;
      end
    endcase
    if (kind == BurstEdge) begin
      case ($urandom_range(0, 3))
        0:       req.position = '0;
        1:       req.position = PosW'(len);
        2:       req.position = PosW'(len + 1);
        default: req.position = PosW'($urandom_range(0, 127));
      endcase
    end else begin
      case ($urandom_range(0, 9))
        0:       req.position = PosW'($urandom_range(0, 127));
        1:       req.position = PosW'(len + 1);
        default: ;
      endcase
    end
    return req;
  endfunction

  task automatic send_beat(input in_t req, input bit typed, input out_t want);
    int   gap;
    out_t predicted;
    gap = sender_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (!(in_valid && in_ready));
    predicted = shadow_apply(req);
    result_q.insert(result_q.size(), typed ? want : predicted);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (result_q.size() != 0);
  endtask

  initial begin : result_monitor
    out_t want;
    int   stall;
    @(posedge rst_ni);
    forever begin
      stall = receiver_calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!(out_valid && out_ready));
      if (result_q.size() == 0) begin
        report_mismatch("beat with nothing expected", out_data, 0);
      end else begin
        want = result_q.pop_front();
        if (out_data.popped_value !== want.popped_value)
          report_mismatch("popped_value", out_data.popped_value, want.popped_value);
        if (out_data.count !== want.count)
          report_mismatch("count", out_data.count, want.count);
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
      end
      beats_seen++;
    end
  end

  initial begin : stimulus
    burst_e kind;
    int     burst_len;
    plan_row(OpPop,      '0,            '0, 1'b1, '0,            7'd0, StEmpty);
    plan_row(OpAt,       32'd5,         7'd1, 1'b1, '0,          7'd0, StRange);
    plan_row(OpAt,       32'h7fff_ffff, 7'd0, 1'b1, '0,          7'd1, StOk);
    plan_row(OpAppend,   32'h8000_0000, 7'd0, 1'b1, '0,          7'd2, StOk);
    plan_row(OpHead,     32'hffff_ffff, 7'd0, 1'b1, '0,          7'd3, StOk);
    plan_row(OpAt,       32'h5555_5555, 7'd3, 1'b1, '0,          7'd4, StOk);
    plan_row(OpAt,       32'haaaa_aaaa, 7'd2, 1'b1, '0,          7'd5, StOk);
    plan_row(OpAt,       32'd1,         7'd6, 1'b1, '0,          7'd5, StRange);
    plan_row(OpAt,       '0,            7'd127, 1'b1, '0,        7'd5, StRange);
    plan_row(OpSpareLo,  32'hffff_ffff, 7'd127, 1'b1, '0,        7'd5, StOk);
    plan_row(OpSpareHi,  32'h1234_5678, 7'd64, 1'b1, '0,         7'd5, StOk);
    plan_row(OpPop,      '0,            '0, 1'b1, 32'hffff_ffff, 7'd4, StOk);
    plan_row(OpPop,      '0,            '0);
    plan_row(OpPop,      '0,            '0);
    plan_row(OpPop,      '0,            '0);
    plan_row(OpPop,      '0,            '0);
    plan_row(OpPop,      '0,            '0, 1'b1, '0,            7'd0, StEmpty);
    plan_row(OpClear,    32'hffff_ffff, 7'd127, 1'b1, '0,        7'd0, StOk);
    plan_row(OpAppend,   '0,            '0);
    plan_row(OpHead,     32'd1,         '0);
    plan_row(OpClear,    '0,            '0, 1'b1, '0,            7'd0, StOk);
    plan_row(OpSpareMid, 32'h8000_0000, 7'd1, 1'b1, '0,          7'd0, StOk);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) send_beat(plan[i].req, plan[i].typed, plan[i].want);
    // hold the sender until every outstanding beat is back
    drain_results();

    while (items_sent < ItemTarget) begin
      kind          = burst_e'($urandom_range(0, 3));
      burst_len     = $urandom_range(10, 120);
      sender_calm   = ($urandom_range(0, 3) == 0);
      receiver_calm = ($urandom_range(0, 3) == 0);
      repeat (burst_len) send_beat(random_request(kind), 1'b0, '0);
      if ($urandom_range(0, 4) == 0) drain_results();
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (result_q.size() != 0) report_mismatch("beats still outstanding", result_q.size(), 0);
    if (error_count == 0) begin
      $display("tb_positional_insert_queue: done, clean");
    end else begin
      $display("tb_positional_insert_queue: done, errors");
    end
    $finish;
  end

endmodule
